/* sv/tms_pkg.sv */
// ============================================================================
// tms_pkg: shared types, defaults and helpers of the transform matrix stack
// Holds the Q16.16 saturation helper, parameter defaults and command codes.
// ============================================================================
package tms_pkg;

  localparam int unsigned DEF_STACK_DEPTH = 128;
  localparam int unsigned DEF_FRAC_BITS   = 16;
  localparam int unsigned DEF_WORD_BITS   = 32;

  typedef enum logic [3:0] {
    CMD_SELECT   = 4'd0,
    CMD_IDENTITY = 4'd1,
    CMD_STAGE    = 4'd2,
    CMD_LOAD     = 4'd3,
    CMD_MULTIPLY = 4'd4,
    CMD_TRANSLATE = 4'd5,
    CMD_SCALE    = 4'd6,
    CMD_PUSH     = 4'd7,
    CMD_POP      = 4'd8,
    CMD_READ     = 4'd9
  } cmd_t;

  localparam logic [1:0] ST_OK        = 2'd0;
  localparam logic [1:0] ST_PUSH_FULL = 2'd1;
  localparam logic [1:0] ST_POP_EMPTY = 2'd2;

  // Issue control of one multiply-accumulate step
  typedef struct packed {
    logic       valid;
    logic       first;
    logic       last;
    logic [3:0] idx;
  } mac_ctl_t;

  // Finished dot product
  typedef struct packed {
    logic               valid;
    logic [3:0]         idx;
    logic signed [31:0] data;
  } mac_res_t;

  // Clamp a wide signed value to a signed word of the given width
  function automatic logic signed [31:0] sat_word(input logic signed [65:0] v,
                                                  input int unsigned bits);
    logic signed [65:0] hi;
    logic signed [65:0] lo;
    hi = (66'sd1 <<< (bits - 1)) - 66'sd1;
    lo = -hi - 66'sd1;
    if (v > hi) return hi[31:0];
    if (v < lo) return lo[31:0];
    return v[31:0];
  endfunction

endpackage

/* sv/tms_if.sv */
// ============================================================================
// tms_if: command and result channels of the transform matrix stack
// Valid/ready channels; a transaction completes when both are high.
// ============================================================================
interface tms_cmd_if;
  logic               valid;
  logic               ready;
  logic [3:0]         command;
  logic               matrix_select;
  logic [3:0]         element_index;
  logic signed [31:0] element_value;
  logic signed [31:0] coord_x;
  logic signed [31:0] coord_y;
  logic signed [31:0] coord_z;

  modport source (output valid, command, matrix_select, element_index, element_value,
                  coord_x, coord_y, coord_z, input ready);
  modport sink   (input valid, command, matrix_select, element_index, element_value,
                  coord_x, coord_y, coord_z, output ready);
endinterface

interface tms_res_if;
  logic               valid;
  logic               ready;
  logic signed [31:0] read_value;
  logic [7:0]         stack_level;
  logic [1:0]         status;
  logic               active_mode;

  modport source (output valid, read_value, stack_level, status, active_mode, input ready);
  modport sink   (input valid, read_value, stack_level, status, active_mode, output ready);
endinterface

/* sv/tms_mac.sv */
// ============================================================================
// tms_mac: shared multiply-accumulate unit
// One 32x32 product per cycle, exact 66-bit sum, floor shift and saturation.
// ============================================================================
module tms_mac import tms_pkg::*; #(
  parameter int unsigned FRAC_BITS = DEF_FRAC_BITS,
  parameter int unsigned SAT_BITS  = DEF_WORD_BITS
) (
  input  logic               clk,
  input  logic               rst_n,
  input  mac_ctl_t           ctl_in,
  input  logic signed [31:0] a,
  input  logic signed [31:0] b,
  output mac_res_t           res
);

  logic signed [63:0] prod_r;
  mac_ctl_t           ctl_r;
  logic signed [65:0] acc_r;
  logic signed [65:0] acc_sum;

  assign acc_sum = (ctl_r.first ? 66'sd0 : acc_r) + {{2{prod_r[63]}}, prod_r};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ctl_r <= '0;
    end else begin
      ctl_r <= ctl_in;
    end
    prod_r <= a * b;
    if (ctl_r.valid) acc_r <= acc_sum;
  end

  assign res.valid = ctl_r.valid && ctl_r.last;
  assign res.idx   = ctl_r.idx;
  assign res.data  = sat_word(acc_sum >>> FRAC_BITS, SAT_BITS);

endmodule

/* sv/transform_matrix_stack.sv */
// ============================================================================
// transform_matrix_stack: fixed-function 4x4 transform unit, signed Q16.16
// Modelview/projection matrices, staging matrix and a shared save stack.
// ============================================================================
// Usage:
//   in_cmd carries one command per transaction; out_res returns exactly one
//   result transaction per command, in order.
//   One command is worked on at a time; in_cmd.ready is high only while idle.
// Work per command:
//   select, identity, stage, load, read, refused push/pop: done in execute
//   push, pop: one save-stack word per cycle
//   multiply, translate, scale: the single shared multiplier
//   runs the 64 multiply-accumulates of the 4x4 product, one per cycle.
// Reset: both matrices become identity, staging clears, stack empties and
//   projection is selected. The save stack memory is not cleared.
// Stall: a result held in out_res does not stop the next command from being
//   accepted and worked; it waits in its finish step until out_res drains.
// ============================================================================
module transform_matrix_stack import tms_pkg::*; #(
  parameter int unsigned STACK_DEPTH = DEF_STACK_DEPTH,
  parameter int unsigned FRAC_BITS   = DEF_FRAC_BITS,
  parameter int unsigned WORD_BITS   = DEF_WORD_BITS
) (
  input logic        clk,
  input logic        rst_n,
  tms_cmd_if.sink    in_cmd,
  tms_res_if.source  out_res
);

  localparam int unsigned SAT_BITS  = (WORD_BITS > 32) ? 32 : WORD_BITS;
  localparam int unsigned CNT_W     = $clog2(STACK_DEPTH + 1);
  localparam int unsigned SIDX_W    = (STACK_DEPTH > 1) ? $clog2(STACK_DEPTH) : 1;
  localparam int unsigned MEM_DEPTH = STACK_DEPTH * 16;
  localparam int unsigned AW        = $clog2(MEM_DEPTH);
  localparam logic signed [31:0] ONE_VAL = sat_word(66'sd1 <<< FRAC_BITS, SAT_BITS);

  typedef enum logic [3:0] {
    S_IDLE, S_EXEC, S_MUL, S_MDRAIN, S_COPY, S_PUSH, S_POP, S_PDRAIN, S_FINISH
  } state_t;

  state_t             state_r;
  state_t             exec_state_nxt;
  logic [1:0]         status_nxt;
  logic [3:0]         cmd_r;
  logic [3:0]         idx_r;
  logic               sel_r;
  logic signed [31:0] val_r, x_r, y_r, z_r;
  logic               mode_r;
  logic [CNT_W-1:0]   stack_cnt_r;
  logic [5:0]         cnt_r;
  logic signed [31:0] rd_r;
  logic [1:0]         status_r;
  logic signed [31:0] cur_r   [32];
  logic signed [31:0] stage_r [16];
  logic signed [31:0] tmp_r   [16];
  logic               pop_v_r;
  logic [3:0]         pop_i_r;

  logic signed [31:0] mem [MEM_DEPTH];
  logic signed [31:0] mem_q_r;
  logic               mem_we;
  logic [AW-1:0]      mem_addr;

  logic [4:0]         cur_addr;
  logic signed [31:0] cur_rd;
  logic signed [31:0] op_b;
  mac_ctl_t           mac_ctl;
  mac_res_t           mac_res;

  logic out_valid_r;
  logic signed [31:0] out_rd_r;
  logic [7:0]         out_lvl_r;
  logic [1:0]         out_st_r;
  logic               out_mode_r;

  // Operand element j (column-major) of the post-multiply operand
  function automatic logic signed [31:0] op_elem(input logic [3:0] cmd, input logic [3:0] j,
                                                 input logic signed [31:0] st,
                                                 input logic signed [31:0] x,
                                                 input logic signed [31:0] y,
                                                 input logic signed [31:0] z);
    logic diag;
    diag = (j[1:0] == j[3:2]);
    if (cmd == CMD_TRANSLATE) begin
      if (j == 4'd12) return x;
      if (j == 4'd13) return y;
      if (j == 4'd14) return z;
      return diag ? ONE_VAL : 32'sd0;
    end
    if (cmd == CMD_SCALE) begin
      if (j == 4'd0)  return x;
      if (j == 4'd5)  return y;
      if (j == 4'd10) return z;
      if (j == 4'd15) return ONE_VAL;
      return 32'sd0;
    end
    return st;
  endfunction

  assign in_cmd.ready = (state_r == S_IDLE);

  // Single read port of the current matrices; the sequencer steers it.
  // MAC step cnt: column c = cnt[5:4], row = cnt[3:2], term k = cnt[1:0].
  always_comb begin
    unique case (state_r)
      S_MUL:   cur_addr = {mode_r, cnt_r[1:0], cnt_r[3:2]};
      S_PUSH:  cur_addr = {mode_r, cnt_r[3:0]};
      default: cur_addr = {mode_r, idx_r};
    endcase
  end
  assign cur_rd = cur_r[cur_addr];

  // Pick the follow-up step and status of the command in execute
  always_comb begin
    status_nxt     = ST_OK;
    exec_state_nxt = S_FINISH;
    unique case (cmd_r)
      CMD_MULTIPLY, CMD_TRANSLATE, CMD_SCALE: exec_state_nxt = S_MUL;
      CMD_PUSH: begin
        if (stack_cnt_r == CNT_W'(STACK_DEPTH)) status_nxt = ST_PUSH_FULL;
        else exec_state_nxt = S_PUSH;
      end
      CMD_POP: begin
        if (stack_cnt_r == '0) status_nxt = ST_POP_EMPTY;
        else exec_state_nxt = S_POP;
      end
      default: ;
    endcase
  end

  assign op_b = op_elem(cmd_r, {cnt_r[5:4], cnt_r[1:0]}, stage_r[{cnt_r[5:4], cnt_r[1:0]}],
                        x_r, y_r, z_r);

  assign mac_ctl.valid = (state_r == S_MUL);
  assign mac_ctl.first = (cnt_r[1:0] == 2'd0);
  assign mac_ctl.last  = (cnt_r[1:0] == 2'd3);
  assign mac_ctl.idx   = {cnt_r[5:4], cnt_r[3:2]};

  tms_mac #(.FRAC_BITS(FRAC_BITS), .SAT_BITS(SAT_BITS)) u_mac (
    .clk    (clk),
    .rst_n  (rst_n),
    .ctl_in (mac_ctl),
    .a      (cur_rd),
    .b      (op_b),
    .res    (mac_res)
  );

  // Save stack: push writes, pop reads, one word per cycle at {slot, word}
  assign mem_we   = (state_r == S_PUSH);
  assign mem_addr = AW'({stack_cnt_r[SIDX_W-1:0], cnt_r[3:0]});

  always_ff @(posedge clk) begin
    if (mem_we) mem[mem_addr] <= cur_rd;
    mem_q_r <= mem[mem_addr];
  end

  always_ff @(posedge clk) begin
    if (mac_res.valid) tmp_r[mac_res.idx] <= mac_res.data;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      mode_r      <= 1'b1;
      stack_cnt_r <= '0;
      cnt_r       <= '0;
      pop_v_r     <= 1'b0;
      out_valid_r <= 1'b0;
      for (int i = 0; i < 32; i++) begin
        cur_r[i] <= (i[1:0] == i[3:2]) ? ONE_VAL : 32'sd0;
      end
      for (int i = 0; i < 16; i++) stage_r[i] <= 32'sd0;
    end else begin
      // drop the result once the receiver takes it
      if (out_res.ready && state_r != S_FINISH) out_valid_r <= 1'b0;
      // write back the save-stack word read in the previous pop step
      pop_v_r <= (state_r == S_POP);
      if (pop_v_r) cur_r[{mode_r, pop_i_r}] <= mem_q_r;

      unique case (state_r)
        S_IDLE: begin
          if (in_cmd.valid) begin
            cmd_r    <= in_cmd.command;
            idx_r    <= in_cmd.element_index;
            sel_r    <= in_cmd.matrix_select;
            val_r    <= sat_word({{34{in_cmd.element_value[31]}}, in_cmd.element_value},
                                 SAT_BITS);
            x_r      <= sat_word({{34{in_cmd.coord_x[31]}}, in_cmd.coord_x}, SAT_BITS);
            y_r      <= sat_word({{34{in_cmd.coord_y[31]}}, in_cmd.coord_y}, SAT_BITS);
            z_r      <= sat_word({{34{in_cmd.coord_z[31]}}, in_cmd.coord_z}, SAT_BITS);
            state_r  <= S_EXEC;
          end
        end
        S_EXEC: begin
          rd_r     <= (cmd_r == CMD_READ) ? cur_rd : 32'sd0;
          status_r <= status_nxt;
          cnt_r    <= '0;
          state_r  <= exec_state_nxt;
          unique case (cmd_r)
            CMD_SELECT: mode_r <= sel_r;
            CMD_IDENTITY: begin
              for (int i = 0; i < 16; i++) begin
                cur_r[{mode_r, 4'(i)}] <= (i[1:0] == i[3:2]) ? ONE_VAL : 32'sd0;
              end
            end
            CMD_STAGE: stage_r[idx_r] <= val_r;
            CMD_LOAD: begin
              for (int i = 0; i < 16; i++) cur_r[{mode_r, 4'(i)}] <= stage_r[i];
            end
            CMD_POP: begin
              if (stack_cnt_r != '0) stack_cnt_r <= stack_cnt_r - 1'b1;
            end
            default: ;
          endcase
        end
        S_MUL: begin
          cnt_r <= cnt_r + 1'b1;
          if (cnt_r == 6'd63) state_r <= S_MDRAIN;
        end
        S_MDRAIN: state_r <= S_COPY;
        S_COPY: begin
          for (int i = 0; i < 16; i++) cur_r[{mode_r, 4'(i)}] <= tmp_r[i];
          state_r <= S_FINISH;
        end
        S_PUSH: begin
          cnt_r <= cnt_r + 1'b1;
          if (cnt_r[3:0] == 4'd15) begin
            stack_cnt_r <= stack_cnt_r + 1'b1;
            state_r     <= S_FINISH;
          end
        end
        S_POP: begin
          pop_i_r <= cnt_r[3:0];
          cnt_r   <= cnt_r + 1'b1;
          if (cnt_r[3:0] == 4'd15) state_r <= S_PDRAIN;
        end
        S_PDRAIN: state_r <= S_FINISH;
        S_FINISH: begin
          // hold until the output register is free
          if (!out_valid_r || out_res.ready) begin
            out_valid_r <= 1'b1;
            out_rd_r    <= rd_r;
            out_lvl_r   <= 8'(stack_cnt_r);
            out_st_r    <= status_r;
            out_mode_r  <= mode_r;
            state_r     <= S_IDLE;
          end
        end
        default: state_r <= S_IDLE;
      endcase
    end
  end

  assign out_res.valid       = out_valid_r;
  assign out_res.read_value  = out_rd_r;
  assign out_res.stack_level = out_lvl_r;
  assign out_res.status      = out_st_r;
  assign out_res.active_mode = out_mode_r;

endmodule

/* sv/tms_checker.sv */
// ============================================================================
// tms_checker: port-level checks of the transform matrix stack
// Watches the channels and flags inconsistent results.
// ============================================================================
module tms_checker import tms_pkg::*; #(
  parameter int unsigned STACK_DEPTH = DEF_STACK_DEPTH
) (
  input logic               clk,
  input logic               rst_n,
  input logic               in_valid,
  input logic               in_ready,
  input logic               out_valid,
  input logic               out_ready,
  input logic signed [31:0] read_value,
  input logic [7:0]         stack_level,
  input logic [1:0]         status
);

  a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready |=> !in_ready)
    else $error("command accepted while busy");

  a_status_code: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> status != 2'd3)
    else $error("undefined status code");

  a_full_level: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && status == ST_PUSH_FULL |-> stack_level == 8'(STACK_DEPTH))
    else $error("push refused below full stack");

  a_empty_level: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && status == ST_POP_EMPTY |-> stack_level == 8'd0)
    else $error("pop refused on non-empty stack");

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(read_value))
    else $error("stalled result changed");

endmodule

bind transform_matrix_stack tms_checker #(.STACK_DEPTH(STACK_DEPTH)) u_tms_checker (
  .clk         (clk),
  .rst_n       (rst_n),
  .in_valid    (in_cmd.valid),
  .in_ready    (in_cmd.ready),
  .out_valid   (out_res.valid),
  .out_ready   (out_res.ready),
  .read_value  (out_res.read_value),
  .stack_level (out_res.stack_level),
  .status      (out_res.status)
);
